@@ rtl/core/lpfc_pkg.sv @@
// Shared types and constants for the LCD panel frame capture block.
// No dependencies; lpfc_regs, lpfc_seq, lpfc_emit and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package lpfc_pkg;

    // Panel geometry the block comes out of reset for
    localparam int PANEL_WIDTH  = 640;
    localparam int PANEL_HEIGHT = 400;

    localparam int DEF_MAX_ROW_BYTES = 128;
    localparam int DEF_MAX_LINES     = 512;

    localparam int ADDR_W  = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic       MODE_DSTN = 1'b0;
    localparam logic       MODE_TFT  = 1'b1;

    localparam logic       ACT_SAMPLE      = 1'b0;
    localparam logic       ACT_FRAME_START = 1'b1;

    localparam logic [7:0] HI_NIBBLE = 8'hF0;
    localparam logic [7:0] LO_NIBBLE = 8'h0F;

    localparam logic       RESET_MODE        = MODE_DSTN;
    localparam logic [7:0] RESET_ROW_BYTES   = 8'(PANEL_WIDTH / 8);
    localparam logic [9:0] RESET_PANEL_LINES = 10'(PANEL_HEIGHT);
    localparam logic [3:0] RESET_DISCARD     = 4'd1;

    typedef enum logic [1:0] {
        REG_CAPTURE_MODE    = 2'd0,
        REG_ROW_BYTES       = 2'd1,
        REG_PANEL_LINES     = 2'd2,
        REG_DISCARD_SAMPLES = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_DISCARD = 3'b010,
        PH_CAPTURE = 3'b100
    } phase_t;

    // One capture job: a TFT byte or a DSTN pair
    typedef struct packed {
        logic              is_tft;
        logic [ADDR_W-1:0] seq_addr;
        logic [7:0]        data0;
        logic [7:0]        data1;
        logic              fend;
    } job_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              last;
        logic              fend;
    } wr_t;

endpackage

`default_nettype wire

@@ rtl/core/lpfc_regs.sv @@
// APB configuration registers with range clamping of row bytes and line count.
// Depends on lpfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpfc_regs #(
    parameter int MAX_ROW_BYTES = 128,
    parameter int MAX_LINES     = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lpfc_pkg::PADDR_W-1:0]    paddr,
    input  logic [lpfc_pkg::PDATA_W-1:0]    pwdata,
    output logic [lpfc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    output logic                            mode,
    output logic [$clog2(MAX_ROW_BYTES):0]  rb,
    output logic [$clog2(MAX_LINES):0]      lines,
    output logic [$clog2(MAX_LINES)-1:0]    half,
    output logic [3:0]                      discard
);
    import lpfc_pkg::*;

    localparam int RB_W = $clog2(MAX_ROW_BYTES) + 1;
    localparam int LN_W = $clog2(MAX_LINES) + 1;

    logic       mode_reg;
    logic [7:0] rowb_reg;
    logic [9:0] lines_reg;
    logic [3:0] disc_reg;
    logic       wr_en;
    reg_idx_t   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= RESET_MODE;
            rowb_reg  <= RESET_ROW_BYTES;
            lines_reg <= RESET_PANEL_LINES;
            disc_reg  <= RESET_DISCARD;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CAPTURE_MODE:    mode_reg  <= pwdata[0];
                REG_ROW_BYTES:       rowb_reg  <= pwdata[7:0];
                REG_PANEL_LINES:     lines_reg <= pwdata[9:0];
                REG_DISCARD_SAMPLES: disc_reg  <= pwdata[3:0];
                default:             mode_reg  <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CAPTURE_MODE:    prdata = PDATA_W'(mode_reg);
            REG_ROW_BYTES:       prdata = PDATA_W'(rowb_reg);
            REG_PANEL_LINES:     prdata = PDATA_W'(lines_reg);
            REG_DISCARD_SAMPLES: prdata = PDATA_W'(disc_reg);
            default:             prdata = '0;
        endcase
    end

    // Clamp to the supported range
    always_comb
    begin
        if (rowb_reg == 8'd0)
            rb = RB_W'(1);
        else if ({1'b0, rowb_reg} > 9'(MAX_ROW_BYTES))
            rb = RB_W'(MAX_ROW_BYTES);
        else
            rb = RB_W'(rowb_reg);

        if (lines_reg < 10'd2)
            lines = LN_W'(2);
        else if ({1'b0, lines_reg} > 11'(MAX_LINES))
            lines = LN_W'(MAX_LINES);
        else
            lines = LN_W'(lines_reg);
    end

    assign half    = lines[LN_W-1:1];
    assign mode    = mode_reg;
    assign discard = disc_reg;

endmodule

`default_nettype wire

@@ rtl/core/lpfc_seq.sv @@
// Capture sequencer: frame arming, discard, TFT byte count and DSTN pairing.
// Emits one job register per producing request. Depends on lpfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpfc_seq #(
    parameter int MAX_ROW_BYTES = 128,
    parameter int MAX_LINES     = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic                              action,
    input  logic [7:0]                        sample_byte,
    input  logic                              mode,
    input  logic [$clog2(MAX_ROW_BYTES):0]    rb,
    input  logic [$clog2(MAX_LINES):0]        lines,
    input  logic [$clog2(MAX_LINES)-1:0]      half,
    input  logic [3:0]                        discard,
    output logic                              job_valid,
    input  logic                              job_ready,
    output lpfc_pkg::job_t                    job,
    output logic [$clog2(MAX_ROW_BYTES)-1:0]  job_col,
    output logic [$clog2(MAX_LINES):0]        job_line
);
    import lpfc_pkg::*;

    localparam int RB_W  = $clog2(MAX_ROW_BYTES) + 1;
    localparam int COL_W = RB_W - 1;
    localparam int LN_W  = $clog2(MAX_LINES) + 1;
    localparam int SL_W  = LN_W - 1;
    localparam int TW    = LN_W + RB_W;
    localparam int CW    = (TW > ADDR_W + 1) ? TW : ADDR_W + 1;

    phase_t            phase_reg, phase_next;
    logic [3:0]        dleft_reg, dleft_next, dleft_dec;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [SL_W-1:0]   sl_reg, sl_next;
    logic [7:0]        held_reg, held_next;
    logic              pair_reg, pair_next;
    logic [ADDR_W-1:0] seq_reg, seq_next;

    logic              job_v_reg;
    job_t              job_reg, job_next;
    logic [COL_W-1:0]  jcol_reg;
    logic [LN_W-1:0]   jline_reg;

    logic              accept, produce;
    logic [TW-1:0]     total;
    logic [ADDR_W:0]   seq_p1;
    logic              tft_done;
    logic [RB_W-1:0]   col_p1;
    logic              line_done;
    logic [LN_W-1:0]   sl_p1;
    logic              frame_done;
    logic [7:0]        upper_byte, lower_byte;

    assign item_ready = !job_v_reg || job_ready;
    assign accept     = item_valid && item_ready;

    assign total      = TW'(lines) * TW'(rb);
    assign seq_p1     = (ADDR_W + 1)'(seq_reg) + (ADDR_W + 1)'(1);
    assign tft_done   = CW'(seq_p1) >= CW'(total);
    assign col_p1     = RB_W'(col_reg) + RB_W'(1);
    assign line_done  = col_p1 >= rb;
    assign sl_p1      = LN_W'(sl_reg) + LN_W'(1);
    assign frame_done = line_done && (sl_p1 >= LN_W'(half));
    assign dleft_dec  = dleft_reg - 4'(dleft_reg != 4'd0);

    assign upper_byte = (sample_byte & HI_NIBBLE) | ((held_reg & HI_NIBBLE) >> 4);
    assign lower_byte = ((sample_byte & LO_NIBBLE) << 4) | (held_reg & LO_NIBBLE);

    always_comb
    begin
        phase_next = phase_reg;
        dleft_next = dleft_reg;
        col_next   = col_reg;
        sl_next    = sl_reg;
        held_next  = held_reg;
        pair_next  = pair_reg;
        seq_next   = seq_reg;
        produce    = 1'b0;
        job_next   = job_reg;

        if (accept)
        begin
            if (action == ACT_FRAME_START)
            begin
                // Arm only from idle; a marker mid-frame is dropped
                if (phase_reg == PH_IDLE)
                begin
                    col_next  = '0;
                    sl_next   = '0;
                    held_next = '0;
                    pair_next = 1'b0;
                    seq_next  = '0;
                    if (mode == MODE_DSTN && discard != 4'd0)
                    begin
                        dleft_next = discard;
                        phase_next = PH_DISCARD;
                    end
                    else
                    begin
                        dleft_next = '0;
                        phase_next = PH_CAPTURE;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_DISCARD:
                    begin
                        dleft_next = dleft_dec;
                        if (dleft_dec == 4'd0)
                            phase_next = PH_CAPTURE;
                    end
                    PH_CAPTURE:
                    begin
                        if (mode == MODE_TFT)
                        begin
                            produce           = 1'b1;
                            job_next.is_tft   = 1'b1;
                            job_next.seq_addr = seq_reg;
                            job_next.data0    = sample_byte;
                            job_next.data1    = sample_byte;
                            job_next.fend     = tft_done;
                            seq_next          = seq_p1[ADDR_W-1:0];
                            if (tft_done)
                                phase_next = PH_IDLE;
                        end
                        else if (!pair_reg)
                        begin
                            held_next = sample_byte;
                            pair_next = 1'b1;
                        end
                        else
                        begin
                            produce           = 1'b1;
                            job_next.is_tft   = 1'b0;
                            job_next.seq_addr = seq_reg;
                            job_next.data0    = upper_byte;
                            job_next.data1    = lower_byte;
                            job_next.fend     = frame_done;
                            pair_next         = 1'b0;
                            if (line_done)
                            begin
                                col_next = '0;
                                sl_next  = sl_p1[SL_W-1:0];
                            end
                            else
                            begin
                                col_next = col_p1[COL_W-1:0];
                            end
                            if (frame_done)
                                phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            dleft_reg <= '0;
            col_reg   <= '0;
            sl_reg    <= '0;
            pair_reg  <= 1'b0;
            seq_reg   <= '0;
            job_v_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            dleft_reg <= dleft_next;
            col_reg   <= col_next;
            sl_reg    <= sl_next;
            pair_reg  <= pair_next;
            seq_reg   <= seq_next;
            if (item_ready)
                job_v_reg <= produce;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        if (produce)
        begin
            job_reg   <= job_next;
            jcol_reg  <= col_reg;
            jline_reg <= sl_p1;
        end
    end

    assign job_valid = job_v_reg;
    assign job       = job_reg;
    assign job_col   = jcol_reg;
    assign job_line  = jline_reg;

endmodule

`default_nettype wire

@@ rtl/core/lpfc_mod.sv @@
// Pipelined remainder unit: four restoring steps per stage, payload rides along.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module lpfc_mod #(
    parameter int AW = 10,
    parameter int HW = 9,
    parameter int PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [AW-1:0] num,
    input  logic [HW-1:0] divisor,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [HW-1:0] rem,
    output logic [PW-1:0] out_pay
);
    localparam int STEPS  = 4;
    localparam int STAGES = (AW + STEPS - 1) / STEPS;
    localparam int NW     = STAGES * STEPS;

    logic          v_reg    [STAGES];
    logic [HW-1:0] rem_reg  [STAGES];
    logic [NW-1:0] num_reg  [STAGES];
    logic [PW-1:0] pay_reg  [STAGES];
    logic          v_src    [STAGES];
    logic [HW-1:0] rem_src  [STAGES];
    logic [NW-1:0] num_src  [STAGES];
    logic [PW-1:0] pay_src  [STAGES];
    logic [HW-1:0] rem_next [STAGES];
    logic [NW-1:0] num_next [STAGES];
    logic          rdy      [STAGES+1];

    // Partial remainder stays below the divisor between steps
    function automatic logic [HW+NW-1:0] step_n(input logic [HW-1:0] r_in,
                                                input logic [NW-1:0] n_in,
                                                input logic [HW-1:0] d);
        logic [HW:0]   r;
        logic [NW-1:0] n;
        r = {1'b0, r_in};
        n = n_in;
        for (int i = 0; i < STEPS; i++)
        begin
            r = {r[HW-1:0], n[NW-1]};
            n = {n[NW-2:0], 1'b0};
            if (r >= {1'b0, d})
                r = r - {1'b0, d};
        end
        return {r[HW-1:0], n};
    endfunction

    assign rdy[STAGES] = out_ready;

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        if (s == 0)
        begin : g_head
            assign v_src[s]   = in_valid;
            assign rem_src[s] = '0;
            assign num_src[s] = NW'(num);
            assign pay_src[s] = in_pay;
        end
        else
        begin : g_body
            assign v_src[s]   = v_reg[s-1];
            assign rem_src[s] = rem_reg[s-1];
            assign num_src[s] = num_reg[s-1];
            assign pay_src[s] = pay_reg[s-1];
        end

        assign {rem_next[s], num_next[s]} = step_n(rem_src[s], num_src[s], divisor);
        assign rdy[s] = !v_reg[s] || rdy[s+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (rdy[s])
                v_reg[s] <= v_src[s];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && v_src[s])
            begin
                rem_reg[s] <= rem_next[s];
                num_reg[s] <= num_next[s];
                pay_reg[s] <= pay_src[s];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[STAGES-1];
    assign rem       = rem_reg[STAGES-1];
    assign out_pay   = pay_reg[STAGES-1];

endmodule

`default_nettype wire

@@ rtl/core/lpfc_emit.sv @@
// Address generation and output register; a DSTN pair leaves as two writes.
// Depends on lpfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpfc_emit #(
    parameter int MAX_ROW_BYTES = 128,
    parameter int MAX_LINES     = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lpfc_pkg::job_t                    job,
    input  logic [$clog2(MAX_ROW_BYTES)-1:0]  col,
    input  logic [$clog2(MAX_LINES)-1:0]      dest_line,
    input  logic [$clog2(MAX_ROW_BYTES):0]    rb,
    input  logic [$clog2(MAX_LINES)-1:0]      half,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lpfc_pkg::wr_t                     wr
);
    import lpfc_pkg::*;

    logic              ov_reg;
    logic              sv_reg;
    wr_t               out_reg;
    wr_t               sec_reg;
    logic              load_out, take;
    logic [ADDR_W-1:0] addr_top, addr_bot;

    // Address arithmetic wraps at 16 bits, so low-order products suffice
    assign addr_top = ADDR_W'(dest_line) * ADDR_W'(rb) + ADDR_W'(col);
    assign addr_bot = (ADDR_W'(dest_line) + ADDR_W'(half)) * ADDR_W'(rb) + ADDR_W'(col);

    assign load_out = !ov_reg || out_ready;
    assign in_ready = load_out && !sv_reg;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (load_out)
        begin
            ov_reg <= sv_reg || take;
            sv_reg <= take && !job.is_tft;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (sv_reg)
            begin
                out_reg <= sec_reg;
            end
            else if (take)
            begin
                if (job.is_tft)
                begin
                    out_reg.addr <= job.seq_addr;
                    out_reg.data <= job.data0;
                    out_reg.last <= 1'b1;
                    out_reg.fend <= job.fend;
                end
                else
                begin
                    // Top half goes out first, bottom half is held behind it
                    out_reg.addr <= addr_top;
                    out_reg.data <= job.data0;
                    out_reg.last <= 1'b0;
                    out_reg.fend <= 1'b0;
                    sec_reg.addr <= addr_bot;
                    sec_reg.data <= job.data1;
                    sec_reg.last <= 1'b1;
                    sec_reg.fend <= job.fend;
                end
            end
        end
    end

    assign out_valid = ov_reg;
    assign wr        = out_reg;

endmodule

`default_nettype wire

@@ rtl/core/lcd_panel_frame_capture_top.sv @@
// LCD panel frame capture, top level: registers, sequencer, remainder pipe, output.
// Depends on lpfc_pkg, lpfc_regs, lpfc_seq, lpfc_mod and lpfc_emit.
//
// Input channel item_valid/item_ready carries action (0 sample, 1 frame start)
// and sample_byte. Output channel write_valid/write_ready carries frame-store
// writes: write_address, write_data, last (final write of a request) and
// frame_end. Configuration goes through the APB port; pready is always high.
// A frame-start request arms capture from idle. TFT mode writes each sample
// in order; DSTN mode drops discard_samples samples, then turns each pair of
// samples into a top-half write followed by a bottom-half write.
// The first write of a request passes through one job register, then the
// four-steps-per-stage remainder pipe that folds the destination line, then
// the output register, before it is presented on the write channel.
// The second write of a pair is presented in the cycle after the first is taken.
// Throughput is one request per cycle while write_ready stays high: one write per
// TFT sample, two writes per DSTN pair, limited by the single output register.
// Reset loads the register defaults (DSTN, 80 bytes, 400 lines, discard 1) and
// leaves the block idle. When write_ready is low the pipe fills and item_ready
// drops; the pending write holds steady until taken.
`timescale 1ns / 1ps
`default_nettype none

module lcd_panel_frame_capture_top #(
    parameter int MAX_ROW_BYTES = lpfc_pkg::DEF_MAX_ROW_BYTES,
    parameter int MAX_LINES     = lpfc_pkg::DEF_MAX_LINES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpfc_pkg::PADDR_W-1:0]  paddr,
    input  logic [lpfc_pkg::PDATA_W-1:0]  pwdata,
    output logic [lpfc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          action,
    input  logic [7:0]                    sample_byte,
    output logic                          write_valid,
    input  logic                          write_ready,
    output logic [lpfc_pkg::ADDR_W-1:0]   write_address,
    output logic [7:0]                    write_data,
    output logic                          last,
    output logic                          frame_end
);
    import lpfc_pkg::*;

    localparam int RB_W  = $clog2(MAX_ROW_BYTES) + 1;
    localparam int COL_W = RB_W - 1;
    localparam int LN_W  = $clog2(MAX_LINES) + 1;
    localparam int HW    = LN_W - 1;
    localparam int PW    = $bits(job_t) + COL_W;

    logic             cfg_mode;
    logic [RB_W-1:0]  cfg_rb;
    logic [LN_W-1:0]  cfg_lines;
    logic [HW-1:0]    cfg_half;
    logic [3:0]       cfg_discard;

    logic             job_valid, job_ready;
    job_t             seq_job;
    logic [COL_W-1:0] seq_col;
    logic [LN_W-1:0]  seq_line;
    logic [PW-1:0]    mod_in_pay, mod_out_pay;

    logic             mod_valid, mod_ready;
    logic [HW-1:0]    mod_rem;
    job_t             emit_job;
    logic [COL_W-1:0] emit_col;
    wr_t              wr;

    lpfc_regs #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_LINES     (MAX_LINES)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (cfg_mode),
        .rb      (cfg_rb),
        .lines   (cfg_lines),
        .half    (cfg_half),
        .discard (cfg_discard)
    );

    lpfc_seq #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_LINES     (MAX_LINES)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .action      (action),
        .sample_byte (sample_byte),
        .mode        (cfg_mode),
        .rb          (cfg_rb),
        .lines       (cfg_lines),
        .half        (cfg_half),
        .discard     (cfg_discard),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job         (seq_job),
        .job_col     (seq_col),
        .job_line    (seq_line)
    );

    assign mod_in_pay = {seq_job, seq_col};

    lpfc_mod #(
        .AW (LN_W),
        .HW (HW),
        .PW (PW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (job_valid),
        .in_ready  (job_ready),
        .num       (seq_line),
        .divisor   (cfg_half),
        .in_pay    (mod_in_pay),
        .out_valid (mod_valid),
        .out_ready (mod_ready),
        .rem       (mod_rem),
        .out_pay   (mod_out_pay)
    );

    assign {emit_job, emit_col} = mod_out_pay;

    lpfc_emit #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_LINES     (MAX_LINES)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mod_valid),
        .in_ready  (mod_ready),
        .job       (emit_job),
        .col       (emit_col),
        .dest_line (mod_rem),
        .rb        (cfg_rb),
        .half      (cfg_half),
        .out_valid (write_valid),
        .out_ready (write_ready),
        .wr        (wr)
    );

    assign write_address = wr.addr;
    assign write_data    = wr.data;
    assign last          = wr.last;
    assign frame_end     = wr.fend;

endmodule

`default_nettype wire

@@ rtl/core/lpfc_checker.sv @@
// Port-level checks for the LCD panel frame capture top level, and their bind.
// Depends on lcd_panel_frame_capture_top's port list only.
`timescale 1ns / 1ps
`default_nettype none

module lpfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        write_valid,
    input logic        write_ready,
    input logic [15:0] write_address,
    input logic [7:0]  write_data,
    input logic        last,
    input logic        frame_end
);

    // A stalled write holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid && !write_ready |=> write_valid && $stable(write_address)
            && $stable(write_data) && $stable(last) && $stable(frame_end))
        else $error("write changed while stalled");

    // Frame completion only on the final write of a request
    a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid && frame_end |-> last)
        else $error("frame_end on a non-final write");

    // Bottom-half write follows its top-half write at once
    a_pair_back: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid && write_ready && !last |=> write_valid && last)
        else $error("second write of a pair missing");

endmodule

bind lcd_panel_frame_capture_top lpfc_checker u_lpfc_checker (.*);

`default_nettype wire
